### sv/sma_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sma_pkg: shared types and constants of the six-axis moving average
// Sample and mean payload structs, lane vectors and pipeline control.
// ---------------------------------------------------------------------------
package sma_pkg;

    localparam int CHANNELS   = 6;
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 20;   // holds +-16 * 32768
    localparam int WINDOW_DEF = 10;

    // one input item: six raw samples
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
        logic signed [SAMPLE_W-1:0] rate_x;
        logic signed [SAMPLE_W-1:0] rate_y;
        logic signed [SAMPLE_W-1:0] rate_z;
    } t_imu_sample;

    // one result item: six window means
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] avg_accel_x;
        logic signed [SAMPLE_W-1:0] avg_accel_y;
        logic signed [SAMPLE_W-1:0] avg_accel_z;
        logic signed [SAMPLE_W-1:0] avg_rate_x;
        logic signed [SAMPLE_W-1:0] avg_rate_y;
        logic signed [SAMPLE_W-1:0] avg_rate_z;
    } t_imu_mean;

    // channel-indexed view, lane 0 = accel x ... lane 5 = rate z
    typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] t_lanes;

    // stage enables handed to the mean dividers
    typedef struct packed {
        logic en_mag;
        logic en_out;
    } t_pipe_ctl;

    function automatic t_lanes sample_to_lanes(input t_imu_sample s);
        t_lanes l;
        l[0] = s.accel_x;
        l[1] = s.accel_y;
        l[2] = s.accel_z;
        l[3] = s.rate_x;
        l[4] = s.rate_y;
        l[5] = s.rate_z;
        return l;
    endfunction

    function automatic t_imu_mean lanes_to_mean(input t_lanes l);
        t_imu_mean m;
        m.avg_accel_x = l[0];
        m.avg_accel_y = l[1];
        m.avg_accel_z = l[2];
        m.avg_rate_x  = l[3];
        m.avg_rate_y  = l[4];
        m.avg_rate_z  = l[5];
        return m;
    endfunction

    function automatic logic signed [SUM_W-1:0] sext_sum(input logic [SAMPLE_W-1:0] v);
        return {{(SUM_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
    endfunction

endpackage

### sv/sma_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sma_if: valid/ready channels of the six-axis moving average
// Sample channel into the block and mean channel out of it.
// ---------------------------------------------------------------------------
interface sma_smp_if import sma_pkg::*; ();
    logic        valid;
    logic        ready;
    t_imu_sample data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sma_avg_if import sma_pkg::*; ();
    logic      valid;
    logic      ready;
    t_imu_mean data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/sma_tap_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sma_tap_cell: one tap of the six-lane window delay line
// Holds one sample per channel and passes it on when the line shifts.
// ---------------------------------------------------------------------------
module sma_tap_cell import sma_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  t_lanes i_tap,
    output t_lanes o_tap
);

    t_lanes r_tap;
    t_lanes n_tap;

    always_comb begin
        n_tap = i_shift ? i_tap : r_tap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap <= '0;
        end else begin
            r_tap <= n_tap;
        end
    end

    assign o_tap = r_tap;

endmodule

### sv/sma_mean_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sma_mean_div: window sum to mean, truncated toward zero
// Sign/magnitude stage, then reciprocal multiply and sign restore.
// ---------------------------------------------------------------------------
module sma_mean_div import sma_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                    i_clk,
    input  t_pipe_ctl               i_ctl,
    input  logic signed [SUM_W-1:0] i_sum,
    output logic [SAMPLE_W-1:0]     o_mean
);

    // ceil(2^SHIFT / WINDOW) gives exact floor division for any SUM_W-bit magnitude
    localparam int          SHIFT      = SUM_W + $clog2(WINDOW);
    localparam int          RECIP_W    = SUM_W + 1;
    localparam int          PROD_W     = SUM_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    logic [SUM_W-1:0]    r_mag;
    logic [SUM_W-1:0]    n_mag;
    logic                r_neg;
    logic                n_neg;
    logic [SAMPLE_W-1:0] r_mean;
    logic [SAMPLE_W-1:0] n_mean;
    logic [PROD_W-1:0]   w_prod;
    logic [SAMPLE_W:0]   w_quo;
    logic [SAMPLE_W:0]   w_signed;

    always_comb begin
        n_neg = i_sum[SUM_W-1];
        n_mag = n_neg ? SUM_W'(-i_sum) : SUM_W'(i_sum);
    end

    // quotient magnitude reaches 32768, hence one spare bit before the sign flip
    always_comb begin
        w_prod   = PROD_W'(r_mag) * PROD_W'(RECIP);
        w_quo    = w_prod[SHIFT +: SAMPLE_W+1];
        w_signed = r_neg ? (~w_quo + 1'b1) : w_quo;
        n_mean   = w_signed[SAMPLE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mag) begin
            r_mag <= n_mag;
            r_neg <= n_neg;
        end
        if (i_ctl.en_out) begin
            r_mean <= n_mean;
        end
    end

    assign o_mean = r_mean;

endmodule

### sv/six_axis_moving_average_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// six_axis_moving_average_core: six-channel boxcar moving average
// WINDOW-tap running mean of three accelerometer and three gyro axes.
// ---------------------------------------------------------------------------
// Takes one six-axis item per clock while the pipeline has room and returns
// one item of six window means per input item, in order. A result passes
// through the sum register, loaded at the accepting edge, then the
// sign/magnitude stage, then the reciprocal multiply into the output register,
// where the result is held until taken. The rate of one item per cycle is set
// by the running-sum update, a single add/subtract per channel against the
// oldest tap of the delay line; the divide by WINDOW is one multiply stage.
// Each stage holds while the one after it is stalled, so input stays ready while
// a result waits and the pipeline has room. Delay line and sums start at zero,
// so the first WINDOW-1 results average in zeros. Means are truncated toward
// zero. WINDOW may be set from 2 to 16.
// ---------------------------------------------------------------------------
module six_axis_moving_average_core import sma_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sma_smp_if.sink   i_smp,
    sma_avg_if.source o_avg
);

    // ---- handshake and stage enables --------------------------------------
    logic      r_v1;        // sum register holds a fresh item
    logic      r_v2;        // magnitude stage holds an item
    logic      r_vo;        // output register holds a result
    t_pipe_ctl w_ctl;
    logic      w_en_sum;
    logic      w_accept;

    // a stage loads when it is empty or the one after it moves on
    always_comb begin
        w_ctl.en_out = !r_vo || o_avg.ready;
        w_ctl.en_mag = !r_v2 || w_ctl.en_out;
        w_en_sum     = !r_v1 || w_ctl.en_mag;
        w_accept     = i_smp.valid && w_en_sum;
    end

    assign i_smp.ready = w_en_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_en_sum) begin
                r_v1 <= w_accept;
            end
            if (w_ctl.en_mag) begin
                r_v2 <= r_v1;
            end
            if (w_ctl.en_out) begin
                r_vo <= r_v2;
            end
        end
    end

    // ---- window delay line: a chain of WINDOW tap cells -------------------
    // tap 0 is the new sample, tap WINDOW the one leaving the window
    t_lanes w_tap [WINDOW+1];

    assign w_tap[0] = sample_to_lanes(i_smp.data);

    for (genvar k = 0; k < WINDOW; k++) begin : g_tap
        sma_tap_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_accept),
            .i_tap   (w_tap[k]),
            .o_tap   (w_tap[k+1])
        );
    end

    // ---- running sums and mean dividers -----------------------------------
    logic signed [SUM_W-1:0] r_sum [CHANNELS];
    logic signed [SUM_W-1:0] n_sum [CHANNELS];
    t_lanes                  w_mean;

    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        // no overflow: sum stays within +-WINDOW * 32768
        always_comb begin
            n_sum[c] = r_sum[c] - sext_sum(w_tap[WINDOW][c]) + sext_sum(w_tap[0][c]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sum[c] <= '0;
            end else if (w_accept) begin
                r_sum[c] <= n_sum[c];
            end
        end

        sma_mean_div #(
            .WINDOW (WINDOW)
        ) u_div (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_sum  (r_sum[c]),
            .o_mean (w_mean[c])
        );
    end

    assign o_avg.valid = r_vo;
    assign o_avg.data  = lanes_to_mean(w_mean);

    // ---- assertions --------------------------------------------------------
    // an accepted item always lands in the sum stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_v1)
        else $error("accepted item did not reach the sum stage");

    // input only stalls when every stage is full and the output is blocked
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_smp.ready |-> (r_v1 && r_v2 && r_vo && !o_avg.ready))
        else $error("input stalled with room in the pipeline");

    // a blocked result keeps the item behind it in the magnitude stage
    a_hold_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && !o_avg.ready && r_v2) |=> r_v2)
        else $error("item dropped from magnitude stage during stall");

    // sums stay put while no item is taken
    a_sum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_sum[0]) && $stable(r_sum[CHANNELS-1]))
        else $error("running sum moved without an accepted item");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the six-axis moving average core
// Streams six-axis items through the core under random idling on both sides,
// predicts every window mean with its own delay lines and running sums, and
// checks each result item field by field in order.
// ---------------------------------------------------------------------------
module tb_top;
    import sma_pkg::*;

    localparam int DEPTH      = WINDOW_DEF;
    localparam int N_RANDOM   = 1200;
    localparam int IDLE_LIMIT = 4000;   // cycles with no handshake at all
    localparam int TAIL       = 20;     // settle time after the last result
    localparam int HOLD_AT    = 400;    // items in before the long back-pressure
    localparam int HOLD_LEN   = 250;
    localparam int MAX_REPORT = 10;

    typedef enum int {
        MODE_FULL,
        MODE_SMALL,
        MODE_HIGH,
        MODE_LOW,
        MODE_EDGE,
        MODE_SPARSE
    } t_stim_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sma_smp_if smp_ch ();
    sma_avg_if avg_ch ();

    six_axis_moving_average_core #(
        .WINDOW (DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_ch),
        .o_avg   (avg_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state: per-lane delay line, running sum, oldest slot
    logic signed [SAMPLE_W-1:0] taps [CHANNELS][DEPTH];
    logic signed [SUM_W-1:0]    sums [CHANNELS];
    int unsigned                oldest_slot;

    t_imu_sample samples_to_send [$];
    t_imu_mean   means_due [$];

    string lane_name [CHANNELS] = '{"avg_accel_x", "avg_accel_y", "avg_accel_z",
                                    "avg_rate_x", "avg_rate_y", "avg_rate_z"};

    int n_sent      = 0;
    int n_checked   = 0;
    int n_bad       = 0;
    int send_gap    = 0;
    int take_gap    = 0;
    int hold_left   = 0;
    logic hold_done = 1'b0;
    int idle_cycles = 0;

    // lane 0 (accel x) sits in the top bits of the packed struct
    function automatic t_imu_mean advance_window(input t_imu_sample s);
        logic [CHANNELS*SAMPLE_W-1:0] flat_in;
        logic [CHANNELS*SAMPLE_W-1:0] flat_out;
        logic signed [SAMPLE_W-1:0]   fresh;
        int acc;
        int mean;
        flat_in = s;
        for (int c = 0; c < CHANNELS; c++) begin
            fresh = flat_in[(CHANNELS-1-c)*SAMPLE_W +: SAMPLE_W];
            acc   = int'(sums[c]) - int'(taps[c][oldest_slot]) + int'(fresh);
            sums[c] = acc[SUM_W-1:0];
            taps[c][oldest_slot] = fresh;
            mean = int'(sums[c]) / DEPTH;   // truncates toward zero
            flat_out[(CHANNELS-1-c)*SAMPLE_W +: SAMPLE_W] = mean[SAMPLE_W-1:0];
        end
        oldest_slot = (oldest_slot + 1) % DEPTH;
        return flat_out;
    endfunction

    function automatic t_imu_sample make_sample(input int ax, input int ay, input int az,
                                                input int rx, input int ry, input int rz);
        t_imu_sample s;
        s.accel_x = ax[SAMPLE_W-1:0];
        s.accel_y = ay[SAMPLE_W-1:0];
        s.accel_z = az[SAMPLE_W-1:0];
        s.rate_x  = rx[SAMPLE_W-1:0];
        s.rate_y  = ry[SAMPLE_W-1:0];
        s.rate_z  = rz[SAMPLE_W-1:0];
        return s;
    endfunction

    function automatic logic [SAMPLE_W-1:0] lane_value(input t_stim_mode m);
        int v;
        case (m)
            MODE_FULL:  v = int'($urandom_range(0, 65535));
            MODE_SMALL: v = int'($urandom_range(0, 40)) - 20;
            MODE_HIGH:  v = 32767 - int'($urandom_range(0, 31));
            MODE_LOW:   v = -32768 + int'($urandom_range(0, 31));
            MODE_EDGE:  v = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
            default:    v = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 65535)) : 0;
        endcase
        return v[SAMPLE_W-1:0];
    endfunction

    // every fourth stretch of 150 items runs with no idling at all
    function automatic bit calm_phase();
        return ((n_sent / 150) % 4) == 3;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_phase() || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic check_means(input t_imu_mean got);
        t_imu_mean                    want;
        logic [CHANNELS*SAMPLE_W-1:0] g;
        logic [CHANNELS*SAMPLE_W-1:0] w;
        if (means_due.size() == 0) begin
            n_bad++;
            if (n_bad <= MAX_REPORT)
                $display("mean item with nothing expected: %h", got);
            return;
        end
        want = means_due.pop_front();
        g = got;
        w = want;
        for (int c = 0; c < CHANNELS; c++) begin
            if (g[(CHANNELS-1-c)*SAMPLE_W +: SAMPLE_W] !== w[(CHANNELS-1-c)*SAMPLE_W +: SAMPLE_W]) begin
                n_bad++;
                if (n_bad <= MAX_REPORT)
                    $display("item %0d %s: expected %0d, got %0d", n_checked, lane_name[c],
                             $signed(w[(CHANNELS-1-c)*SAMPLE_W +: SAMPLE_W]),
                             $signed(g[(CHANNELS-1-c)*SAMPLE_W +: SAMPLE_W]));
            end
        end
        n_checked++;
    endtask

    // driver: offers queued items, random gap after each one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_ch.valid <= 1'b0;
            send_gap     <= 0;
        end else begin
            if (smp_ch.valid && smp_ch.ready) begin
                means_due.push_back(advance_window(smp_ch.data));
                n_sent <= n_sent + 1;
            end
            if (!smp_ch.valid || smp_ch.ready) begin
                if (send_gap > 0) begin
                    smp_ch.valid <= 1'b0;
                    send_gap     <= send_gap - 1;
                end else if (samples_to_send.size() > 0) begin
                    smp_ch.data  <= samples_to_send.pop_front();
                    smp_ch.valid <= 1'b1;
                    send_gap     <= pick_gap();
                end else begin
                    smp_ch.valid <= 1'b0;
                end
            end
        end
    end

    // one long back-pressure stretch so the pipeline fills and stalls input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_sent >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: checks each accepted mean item, random stalls on ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            avg_ch.ready <= 1'b0;
            take_gap     <= 0;
        end else begin
            if (avg_ch.valid && avg_ch.ready)
                check_means(avg_ch.data);
            if (take_gap > 0) begin
                avg_ch.ready <= 1'b0;
                take_gap     <= take_gap - 1;
            end else begin
                avg_ch.ready <= (hold_left == 0);
                take_gap     <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((smp_ch.valid && smp_ch.ready) || (avg_ch.valid && avg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("six_axis_moving_average_core test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int         n_rand;
        int         run;
        int         r;
        t_stim_mode mode;
        logic [CHANNELS*SAMPLE_W-1:0] flat;

        for (int c = 0; c < CHANNELS; c++) begin
            sums[c] = '0;
            for (int k = 0; k < DEPTH; k++)
                taps[c][k] = '0;
        end
        oldest_slot  = 0;
        smp_ch.valid = 1'b0;
        smp_ch.data  = '0;
        avg_ch.ready = 1'b0;

        // start-up with the window filling at full scale, then swing to the
        // opposite extreme, then truncation of small signed sums
        for (int k = 0; k < DEPTH; k++)
            samples_to_send.push_back(make_sample(32767, 32767, 32767, 32767, 32767, 32767));
        for (int k = 0; k < DEPTH; k++)
            samples_to_send.push_back(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
        samples_to_send.push_back(make_sample(-1, 1, -9, 9, -11, 11));
        samples_to_send.push_back(make_sample(32767, -32768, 0, -1, 1, -10));
        samples_to_send.push_back(make_sample(0, 0, 0, 0, 0, 0));
        samples_to_send.push_back(make_sample(-32768, 32767, -5, 5, 16383, -16384));

        // random runs: a mode held for up to two windows so sums reach extremes
        n_rand = 0;
        while (n_rand < N_RANDOM) begin
            r = $urandom_range(0, 99);
            if (r < 30)      mode = MODE_FULL;
            else if (r < 55) mode = MODE_SMALL;
            else if (r < 70) mode = MODE_HIGH;
            else if (r < 85) mode = MODE_LOW;
            else if (r < 93) mode = MODE_EDGE;
            else             mode = MODE_SPARSE;
            run = $urandom_range(1, 2 * DEPTH);
            for (int k = 0; k < run; k++) begin
                for (int c = 0; c < CHANNELS; c++)
                    flat[(CHANNELS-1-c)*SAMPLE_W +: SAMPLE_W] = lane_value(mode);
                samples_to_send.push_back(t_imu_sample'(flat));
            end
            n_rand += run;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (samples_to_send.size() > 0 || smp_ch.valid || means_due.size() > 0)
            @(negedge i_clk);
        repeat (TAIL) @(posedge i_clk);
        @(negedge i_clk);

        if (n_bad == 0 && means_due.size() == 0) begin
            $display("six_axis_moving_average_core test passed");
        end else begin
            $display("six_axis_moving_average_core test failed");
        end
        $finish;
    end

endmodule

### filelist.f
sv/sma_pkg.sv
sv/sma_if.sv
sv/sma_tap_cell.sv
sv/sma_mean_div.sv
sv/six_axis_moving_average_core.sv
tb/sv/tb_top.sv
